/* hdl/hsv_to_rgb_pixel_converter_unit_macros.svh */
// Assertion macros shared by the HSV to RGB converter modules.
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_UNIT_MACROS_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define HSV_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("hsv assertion failed");

// Whenever cond holds, prop must hold after a delay of dly.
`define HSV_ASSERT_DELAY(lbl, cond, dly, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> ##dly (prop)) \
    else $error("hsv assertion failed");

`endif

/* hdl/hsv_pkg.sv */
// Types, constants and helper functions of the HSV to RGB converter.
`default_nettype none
package hsv_pkg;

  // Fixed-point constants.
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] SECTOR_UNITS = 17'd15360;

  // Hue sector codes; any higher sector takes the magenta assignment.
  localparam logic [3:0] SECT_RED    = 4'd0;
  localparam logic [3:0] SECT_YELLOW = 4'd1;
  localparam logic [3:0] SECT_GREEN  = 4'd2;
  localparam logic [3:0] SECT_CYAN   = 4'd3;
  localparam logic [3:0] SECT_BLUE   = 4'd4;

  // One input item.
  typedef struct packed {
    logic [16:0] hue;
    logic [16:0] saturation;
    logic [16:0] brightness;
  } hsv_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsv_out_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic [3:0]  sector;
    logic [15:0] frac;
    logic [16:0] sat;
    logic [16:0] val;
  } hsv_cls_t;

  // Clamp a Q16 fraction to 1.0.
  function automatic logic [16:0] sat_q16(input logic [16:0] x);
    sat_q16 = (x > ONE_Q16) ? ONE_Q16 : x;
  endfunction

  // floor(64 * b / 15) for a remainder b below 15.
  function automatic logic [5:0] frac_tail(input logic [3:0] b);
    case (b)
      4'd0:    frac_tail = 6'd0;
      4'd1:    frac_tail = 6'd4;
      4'd2:    frac_tail = 6'd8;
      4'd3:    frac_tail = 6'd12;
      4'd4:    frac_tail = 6'd17;
      4'd5:    frac_tail = 6'd21;
      4'd6:    frac_tail = 6'd25;
      4'd7:    frac_tail = 6'd29;
      4'd8:    frac_tail = 6'd34;
      4'd9:    frac_tail = 6'd38;
      4'd10:   frac_tail = 6'd42;
      4'd11:   frac_tail = 6'd46;
      4'd12:   frac_tail = 6'd51;
      4'd13:   frac_tail = 6'd55;
      4'd14:   frac_tail = 6'd59;
      default: frac_tail = 6'd0;
    endcase
  endfunction

  // Scale a Q16 fraction to a byte: (x * 255) >> 16.
  function automatic logic [7:0] to_byte(input logic [16:0] x);
    logic [24:0] prod;
    prod = {x, 8'd0} - {8'd0, x};
    to_byte = prod[23:16];
  endfunction

endpackage
`default_nettype wire

/* hdl/hsv_to_rgb_pixel_converter_unit.sv */
// HSV to RGB pixel converter: one result item for every item taken.
// Path of an item: front registers s1 and s2, the queue, then back registers b1,
// b2 and b3, whose valid bit is the result strobe.
// Throughput: one item per cycle; two front stages, a two-entry queue and
// three back stages (saturation products, value products, select and scale).
// busy_o stays low since the back end drains the queue every cycle.
// Reset clears all valid bits and the queue, so items still in flight are dropped.
`default_nettype none
`include "hsv_to_rgb_pixel_converter_unit_macros.svh"
module hsv_to_rgb_pixel_converter_unit import hsv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire hsv_in_t pixel_i,
  output logic         busy_o,
  output logic         result_valid_o,
  output hsv_out_t     result_o
);

  logic     accept;
  logic     cls_valid;
  hsv_cls_t cls;
  logic     q_full, q_empty, q_pop;
  hsv_cls_t q_head;

  assign accept = start_i && !busy_o;
  assign busy_o = q_full;
  assign q_pop  = !q_empty;

  // Front end: take and classify items.
  hsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .cls_valid_o (cls_valid),
    .cls_o       (cls)
  );

  // Queue between the two halves.
  hsv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cls_valid),
    .push_data_i (cls),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // Back end: arithmetic and channel selection.
  hsv_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_pop),
    .cls_i    (q_head),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  // Every taken item has its result taken a fixed number of edges later.
  `HSV_ASSERT_DELAY(a_fixed_latency, accept, 6, result_valid_o)

endmodule
`default_nettype wire

/* hdl/hsv_front.sv */
// Front end: takes items, clamps saturation and value and finds the hue sector and fraction.
`default_nettype none
module hsv_front import hsv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire hsv_in_t  pixel_i,
  output logic          cls_valid_o,
  output hsv_cls_t      cls_o
);

  logic        s1_valid_q;
  logic [3:0]  s1_sector_q, s1_sector_d;
  logic [13:0] s1_rem_q, s1_rem_d;
  logic [16:0] s1_sat_q, s1_val_q;
  logic [14:0] sect_prod;
  logic [16:0] sect_base;
  logic [16:0] rem_full;

  logic        s2_valid_q;
  hsv_cls_t    s2_q, s2_d;
  logic [26:0] div_prod;
  logic [10:0] div_est;
  logic [13:0] div_left;
  logic [10:0] div_quot;
  logic [3:0]  div_rem;
  logic [16:0] frac_sum;

  // Sector is (hue >> 10) / 15, done as a multiply by 137/2048.
  always_comb begin
    sect_prod   = {8'd0, pixel_i.hue[16:10]} * 15'd137;
    s1_sector_d = sect_prod[14:11];
    sect_base   = {3'd0, s1_sector_d, 10'd0} * 17'd15;
    rem_full    = pixel_i.hue - sect_base;
    s1_rem_d    = rem_full[13:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sector_q <= s1_sector_d;
    s1_rem_q    <= s1_rem_d;
    s1_sat_q    <= sat_q16(pixel_i.saturation);
    s1_val_q    <= sat_q16(pixel_i.brightness);
  end

  // Fraction is floor(rem * 64 / 15): quotient by reciprocal, one correction,
  // then a small table for the leftover.
  always_comb begin
    div_prod = {13'd0, s1_rem_q} * 27'd4369;
    div_est  = div_prod[26:16];
    div_left = s1_rem_q - 14'(div_est) * 14'd15;
    if (div_left >= 14'd15) begin
      div_quot = div_est + 11'd1;
      div_rem  = 4'(div_left - 14'd15);
    end else begin
      div_quot = div_est;
      div_rem  = div_left[3:0];
    end
    frac_sum      = {div_quot, 6'd0} + {11'd0, frac_tail(div_rem)};
    s2_d.sector   = s1_sector_q;
    s2_d.frac     = frac_sum[15:0];
    s2_d.sat      = s1_sat_q;
    s2_d.val      = s1_val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  assign cls_valid_o = s2_valid_q;
  assign cls_o       = s2_q;

endmodule
`default_nettype wire

/* hdl/hsv_queue.sv */
// Two-entry queue that decouples the front end from the back end.
`default_nettype none
`include "hsv_to_rgb_pixel_converter_unit_macros.svh"
module hsv_queue import hsv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire hsv_cls_t push_data_i,
  input  wire logic     pop_i,
  output logic          full_o,
  output logic          empty_o,
  output hsv_cls_t      head_o
);

  hsv_cls_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The queue is never written when full unless also read, nor read when empty.
  `HSV_ASSERT_IMP(a_no_overflow, push_i && !pop_i, !full_o)
  `HSV_ASSERT_IMP(a_no_underflow, pop_i, !empty_o)

endmodule
`default_nettype wire

/* hdl/hsv_back.sv */
// Back end: forms p, q and t, picks channels per sector and scales to bytes.
`default_nettype none
module hsv_back import hsv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire hsv_cls_t cls_i,
  output logic          valid_o,
  output hsv_out_t      result_o
);

  // Stage one: saturation products.
  logic        b1_valid_q;
  logic [3:0]  b1_sector_q;
  logic [16:0] b1_val_q, b1_oms_q, b1_sf_q, b1_sf1_q;
  logic [16:0] one_minus_f;
  logic [32:0] sf_prod;
  logic [33:0] sf1_prod;

  always_comb begin
    one_minus_f = ONE_Q16 - {1'b0, cls_i.frac};
    sf_prod     = {16'd0, cls_i.sat} * {17'd0, cls_i.frac};
    sf1_prod    = {17'd0, cls_i.sat} * {17'd0, one_minus_f};
  end

  always_ff @(posedge clk_i) begin
    b1_sector_q <= cls_i.sector;
    b1_val_q    <= cls_i.val;
    b1_oms_q    <= ONE_Q16 - cls_i.sat;
    b1_sf_q     <= sf_prod[32:16];
    b1_sf1_q    <= sf1_prod[32:16];
  end

  // Stage two: scale by the value to get p, q and t.
  logic        b2_valid_q;
  logic [3:0]  b2_sector_q;
  logic [16:0] b2_v_q, b2_p_q, b2_q_q, b2_t_q;
  logic [33:0] p_prod, q_prod, t_prod;

  always_comb begin
    p_prod = {17'd0, b1_val_q} * {17'd0, b1_oms_q};
    q_prod = {17'd0, b1_val_q} * {17'd0, 17'(ONE_Q16 - b1_sf_q)};
    t_prod = {17'd0, b1_val_q} * {17'd0, 17'(ONE_Q16 - b1_sf1_q)};
  end

  always_ff @(posedge clk_i) begin
    b2_sector_q <= b1_sector_q;
    b2_v_q      <= b1_val_q;
    b2_p_q      <= p_prod[32:16];
    b2_q_q      <= q_prod[32:16];
    b2_t_q      <= t_prod[32:16];
  end

  // Stage three: sector selection and byte scaling into the output register.
  logic     b3_valid_q;
  hsv_out_t b3_q, b3_d;
  logic [16:0] sel_r, sel_g, sel_b;

  always_comb begin
    case (b2_sector_q)
      SECT_RED: begin
        sel_r = b2_v_q; sel_g = b2_t_q; sel_b = b2_p_q;
      end
      SECT_YELLOW: begin
        sel_r = b2_q_q; sel_g = b2_v_q; sel_b = b2_p_q;
      end
      SECT_GREEN: begin
        sel_r = b2_p_q; sel_g = b2_v_q; sel_b = b2_t_q;
      end
      SECT_CYAN: begin
        sel_r = b2_p_q; sel_g = b2_q_q; sel_b = b2_v_q;
      end
      SECT_BLUE: begin
        sel_r = b2_t_q; sel_g = b2_p_q; sel_b = b2_v_q;
      end
      default: begin
        sel_r = b2_v_q; sel_g = b2_p_q; sel_b = b2_q_q;
      end
    endcase
    b3_d.red   = to_byte(sel_r);
    b3_d.green = to_byte(sel_g);
    b3_d.blue  = to_byte(sel_b);
  end

  always_ff @(posedge clk_i) begin
    b3_q <= b3_d;
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= valid_i;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
    end
  end

  assign valid_o  = b3_valid_q;
  assign result_o = b3_q;

endmodule
`default_nettype wire

/* tb/tb_hsv_to_rgb_pixel_converter_unit.sv */
// Self-checking testbench for the HSV to RGB pixel converter.
module tb_hsv_to_rgb_pixel_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv_pkg::*;

  // Cycles from the accepting edge to the result strobe, plus some margin.
  localparam int unsigned PIPE_DEPTH   = 5;
  localparam int unsigned SETTLE       = PIPE_DEPTH + 10;
  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam int unsigned HUE_MAX      = 92160;

  // Holds the expected colors of accepted pixels and checks strobed results.
  class color_board;
    hsv_out_t    pending_rgb[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Clamp a Q16 fraction to 1.0.
    function longint unsigned clamp_unit(logic [16:0] x);
      return (x > ONE_Q16) ? ONE_Q16 : x;
    endfunction

    // Scale a Q16 fraction to an 8-bit channel, truncating.
    function logic [7:0] scale_to_byte(longint unsigned x);
      return 8'((x * 255) >> 16);
    endfunction

    // Work out the RGB color of one HSV pixel.
    function hsv_out_t rgb_from_hsv(hsv_in_t px);
      longint unsigned h, s, v, sector, frac, p, q, t, r, g, b;
      hsv_out_t c;
      h      = px.hue;
      s      = clamp_unit(px.saturation);
      v      = clamp_unit(px.brightness);
      sector = h / SECTOR_UNITS;
      frac   = ((h % SECTOR_UNITS) << 16) / SECTOR_UNITS;
      p      = (v * (ONE_Q16 - s)) >> 16;
      q      = (v * (ONE_Q16 - ((s * frac) >> 16))) >> 16;
      t      = (v * (ONE_Q16 - ((s * (ONE_Q16 - frac)) >> 16))) >> 16;
      // Sectors from 360 degrees up share the magenta assignment.
      case (sector)
        SECT_RED: begin
          r = v; g = t; b = p;
        end
        SECT_YELLOW: begin
          r = q; g = v; b = p;
        end
        SECT_GREEN: begin
          r = p; g = v; b = t;
        end
        SECT_CYAN: begin
          r = p; g = q; b = v;
        end
        SECT_BLUE: begin
          r = t; g = p; b = v;
        end
        default: begin
          r = v; g = p; b = q;
        end
      endcase
      c.red   = scale_to_byte(r);
      c.green = scale_to_byte(g);
      c.blue  = scale_to_byte(b);
      return c;
    endfunction

    // Record the expected color of an accepted pixel.
    function void note_pixel(hsv_in_t px);
      pending_rgb.push_back(rgb_from_hsv(px));
    endfunction

    // Compare one channel and report a difference.
    function void check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compare a strobed result with the oldest expected color.
    function void check_rgb(hsv_out_t got);
      hsv_out_t want;
      if (pending_rgb.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                 $time, got.red, got.green, got.blue);
        return;
      end
      want = pending_rgb.pop_front();
      check_channel("red", want.red, got.red);
      check_channel("green", want.green, got.green);
      check_channel("blue", want.blue, got.blue);
    endfunction

    function int unsigned outstanding();
      return pending_rgb.size();
    endfunction
  endclass

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  hsv_in_t  pixel_i = '0;
  logic     busy_o;
  logic     result_valid_o;
  hsv_out_t result_o;

  color_board board = new();

  hsv_to_rgb_pixel_converter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .pixel_i        (pixel_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both handshakes on the values that held during the ending cycle.
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      board.note_pixel(pixel_i);
    end
    if (result_valid_o) begin
      board.check_rgb(result_o);
    end
  end

  function automatic hsv_in_t make_pixel(int unsigned h, int unsigned s, int unsigned v);
    hsv_in_t px;
    px.hue        = 17'(h);
    px.saturation = 17'(s);
    px.brightness = 17'(v);
    return px;
  endfunction

  // Mostly legal fractions, with the ends and some values above 1.0.
  function automatic int unsigned random_fraction();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return ONE_Q16;
      2:       return $urandom_range(0, 131071);
      default: return $urandom_range(0, ONE_Q16);
    endcase
  endfunction

  // Mostly legal hues, with sector edges and the full 17-bit range.
  function automatic int unsigned random_hue();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 6) * SECTOR_UNITS + $urandom_range(0, 2) - 1;
      1:       return $urandom_range(0, 131071);
      default: return $urandom_range(0, HUE_MAX);
    endcase
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_pixel(input hsv_in_t px);
    start_i <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every expected color has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Stimulus: directed corners, then random bursts, most with random gaps.
  initial begin
    hsv_in_t     directed[$];
    int unsigned sent;
    int unsigned burst;
    bit          paused;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sector edges at full saturation and value.
    directed.push_back(make_pixel(0, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(15359, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(15360, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(30720, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(46080, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(61440, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(76800, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(92159, ONE_Q16, ONE_Q16));
    // Exactly 360 degrees gives magenta; hues past it keep that assignment.
    directed.push_back(make_pixel(HUE_MAX, ONE_Q16, ONE_Q16));
    directed.push_back(make_pixel(107520, 50000, 60000));
    directed.push_back(make_pixel(122880, 1, ONE_Q16));
    directed.push_back(make_pixel(131071, 32768, ONE_Q16));
    directed.push_back(make_pixel(100000, 32768, ONE_Q16));
    // Grey, black and mid values.
    directed.push_back(make_pixel(40000, 0, ONE_Q16));
    directed.push_back(make_pixel(40000, ONE_Q16, 0));
    directed.push_back(make_pixel(0, 0, 0));
    directed.push_back(make_pixel(7680, 32768, 32768));
    directed.push_back(make_pixel(1, 65535, 65535));
    // Saturation and value above 1.0 are clamped.
    directed.push_back(make_pixel(20000, 131071, 40000));
    directed.push_back(make_pixel(50000, 30000, 131071));
    directed.push_back(make_pixel(7680, 65537, 65537));

    foreach (directed[i]) begin
      send_pixel(directed[i]);
    end
    wait_drained();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_pixel(make_pixel(random_hue(), random_fraction(), random_fraction()));
        sent++;
      end
      // Some bursts run straight into the next one.
      if ($urandom_range(0, 3) != 0) begin
        idle($urandom_range(1, 8));
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #1ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/hsv_pkg.sv
hdl/hsv_front.sv
hdl/hsv_queue.sv
hdl/hsv_back.sv
hdl/hsv_to_rgb_pixel_converter_unit.sv
tb/tb_hsv_to_rgb_pixel_converter_unit.sv
